// ===== rtl/core/vgm_command_stream_checker_top_macros.svh =====
// Assertion macros for the command stream checker
`ifndef VGM_COMMAND_STREAM_CHECKER_TOP_MACROS_SVH
`define VGM_COMMAND_STREAM_CHECKER_TOP_MACROS_SVH

// check a property on every clock edge outside reset
`define VCSC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition implies another in the following cycle
`define VCSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/vcsc_pkg.sv =====
// Shared types, constants and the command length table of the stream checker
package vcsc_pkg;

	localparam int unsigned NumChips = 2;

	localparam logic [3:0] ClsPsg     = 4'd0;
	localparam logic [3:0] ClsAy      = 4'd1;
	localparam logic [3:0] ClsWait    = 4'd2;
	localparam logic [3:0] ClsFine    = 4'd3;
	localparam logic [3:0] ClsEnd     = 4'd4;
	localparam logic [3:0] ClsUnsup   = 4'd5;
	localparam logic [3:0] ClsQuiet   = 4'd6;
	localparam logic [3:0] ClsBlock   = 4'd7;
	localparam logic [3:0] ClsUnknown = 4'd8;

	localparam logic [7:0] WarnNoiseRate = 8'h01;
	localparam logic [7:0] WarnFixed     = 8'h02;
	localparam logic [7:0] WarnPeriodic  = 8'h04;
	localparam logic [7:0] WarnOddWait   = 8'h08;
	localparam logic [7:0] WarnFine      = 8'h10;
	localparam logic [7:0] WarnUnsup     = 8'h20;
	localparam logic [7:0] WarnEnvelope  = 8'h40;
	localparam logic [7:0] WarnTone      = 8'h80;

	localparam logic [7:0] OpWait    = 8'h61;
	localparam logic [7:0] OpBlock   = 8'h67;
	localparam logic [7:0] OpPsgHi   = 8'h30;

	localparam logic [0:0] AddrSpt  = 1'b0;
	localparam logic [0:0] AddrDlen = 1'b1;

	typedef struct packed {
		logic [3:0] len;
		logic [3:0] cls;
		logic       grp_v;
		logic [4:0] grp;
	} cmd_info_t;

	typedef struct packed {
		logic done;
		logic nonzero;
	} rem_status_t;

	function automatic cmd_info_t cmd_info(input logic [7:0] op);
		cmd_info_t r;
		r = '{len: 4'd0, cls: ClsUnsup, grp_v: 1'b0, grp: 5'd0};
		priority if (op == 8'h30 || op == 8'h50) begin
			r.cls = ClsPsg; r.len = 4'd2;
		end else if (op >= 8'h70 && op <= 8'h7f) begin
			r.cls = ClsFine; r.len = 4'd1;
		end else if (op >= 8'h80 && op <= 8'h8f) begin
			r.cls = ClsQuiet; r.len = 4'd1;
		end else if (op >= 8'hc0 && op <= 8'hc4) begin
			r.grp_v = 1'b1; r.grp = 5'(22 + op[2:0]); r.len = 4'd4;
		end else if (op >= 8'hd0 && op <= 8'hd4) begin
			r.grp_v = 1'b1; r.grp = 5'(27 + op[2:0]); r.len = 4'd4;
		end else begin
			unique case (op)
				8'h4f, 8'h94: begin r.cls = ClsQuiet; r.len = 4'd2; end
				8'h52, 8'h53, 8'ha2, 8'ha3, 8'hb3, 8'hb4, 8'hbb: begin
					r.cls = ClsQuiet; r.len = 4'd3;
				end
				8'h92: begin r.cls = ClsQuiet; r.len = 4'd6; end
				8'h93: begin r.cls = ClsQuiet; r.len = 4'd11; end
				8'he0, 8'hff: begin r.cls = ClsQuiet; r.len = 4'd5; end
				8'h61: begin r.cls = ClsWait; r.len = 4'd3; end
				8'h62, 8'h63: begin r.cls = ClsWait; r.len = 4'd1; end
				8'h66: begin r.cls = ClsEnd; r.len = 4'd1; end
				8'ha0: begin r.cls = ClsAy; r.len = 4'd3; end
				8'h67: begin r.cls = ClsBlock; r.grp_v = 1'b1; r.grp = 5'd10; r.len = 4'd7; end
				8'h68: begin r.cls = ClsBlock; r.grp_v = 1'b1; r.grp = 5'd11; r.len = 4'd12; end
				8'h90, 8'h91, 8'h95: begin r.grp_v = 1'b1; r.grp = 5'd12; r.len = 4'd5; end
				8'h51: begin r.grp_v = 1'b1; r.grp = 5'd0; r.len = 4'd3; end
				8'h54: begin r.grp_v = 1'b1; r.grp = 5'd1; r.len = 4'd3; end
				8'h55: begin r.grp_v = 1'b1; r.grp = 5'd2; r.len = 4'd3; end
				8'h56, 8'h57: begin r.grp_v = 1'b1; r.grp = 5'd3; r.len = 4'd3; end
				8'h58, 8'h59: begin r.grp_v = 1'b1; r.grp = 5'd4; r.len = 4'd3; end
				8'h5a: begin r.grp_v = 1'b1; r.grp = 5'd5; r.len = 4'd3; end
				8'h5b: begin r.grp_v = 1'b1; r.grp = 5'd6; r.len = 4'd3; end
				8'h5c: begin r.grp_v = 1'b1; r.grp = 5'd7; r.len = 4'd3; end
				8'h5d: begin r.grp_v = 1'b1; r.grp = 5'd8; r.len = 4'd3; end
				8'h5e, 8'h5f: begin r.grp_v = 1'b1; r.grp = 5'd9; r.len = 4'd3; end
				8'hb0: begin r.grp_v = 1'b1; r.grp = 5'd13; r.len = 4'd3; end
				8'hb1: begin r.grp_v = 1'b1; r.grp = 5'd14; r.len = 4'd3; end
				8'hb2: begin r.grp_v = 1'b1; r.grp = 5'd15; r.len = 4'd3; end
				8'hb5: begin r.grp_v = 1'b1; r.grp = 5'd16; r.len = 4'd3; end
				8'hb6: begin r.grp_v = 1'b1; r.grp = 5'd17; r.len = 4'd3; end
				8'hb7: begin r.grp_v = 1'b1; r.grp = 5'd18; r.len = 4'd3; end
				8'hb8: begin r.grp_v = 1'b1; r.grp = 5'd19; r.len = 4'd3; end
				8'hb9: begin r.grp_v = 1'b1; r.grp = 5'd20; r.len = 4'd3; end
				8'hba: begin r.grp_v = 1'b1; r.grp = 5'd21; r.len = 4'd3; end
				default: begin r.cls = ClsUnknown; r.len = 4'd0; end
			endcase
		end
		return r;
	endfunction

	function automatic logic pick_chip(input logic sel);
		return (32'(sel) < NumChips) ? sel : 1'(NumChips - 1);
	endfunction

endpackage

// ===== rtl/core/vgm_command_stream_checker_top.sv =====
// Top level of the command stream checker: parser, chip tracking and output register
//
// Input channel: data_byte and restart with in_valid / in_stall; one byte of
// command data per request. restart clears parse state and warnings first.
// Output channel: one record per finished command (opcode, command_class,
// command_offset, wait_samples, warnings) with out_valid / out_stall.
// Each byte is processed in the cycle it is accepted; a record is registered
// and shown the following cycle. A 0x61 wait whose oddness must be checked
// runs the 16-step remainder unit, and no new request is taken until it is done.
// While a record is held by out_stall, no new request is taken.
// Reset clears all parse state, sets samples_per_tick to 735 and data_length
// to all ones. Registers are written over the APB port, by the user only while
// idle, unchecked by the block: samples_per_tick at 0x0, data_length at 0x4.
module vgm_command_stream_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  opcode,
	output logic [3:0]  command_class,
	output logic [31:0] command_offset,
	output logic [15:0] wait_samples,
	output logic [7:0]  warnings,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	typedef enum logic {ST_IDLE, ST_DIV} state_t;

	state_t state_q;
	logic [15:0] spt_q;
	logic [31:0] dlen_q;

	logic [7:0]  phase_q;
	logic [31:0] left_q, pos_q, args_q, opoff_q, unsup_q;
	logic        payload_q, stopped_q, parity_q;
	logic [7:0]  warned_q;
	logic [2:0]  latch_q;
	logic [1:0]  wcnt_q;
	logic [9:0]  tone_q  [vcsc_pkg::NumChips];
	logic [3:0]  noise_q [vcsc_pkg::NumChips];
	logic [11:0] env_q   [vcsc_pkg::NumChips];
	logic [11:0] ayt_q   [vcsc_pkg::NumChips][3];

	logic [7:0]  n_phase;
	logic [31:0] n_left, n_pos, n_args, n_opoff, n_unsup;
	logic        n_payload, n_stopped, n_parity;
	logic [7:0]  n_warned;
	logic [2:0]  n_latch;
	logic [1:0]  n_wcnt;
	logic [9:0]  n_tone  [vcsc_pkg::NumChips];
	logic [3:0]  n_noise [vcsc_pkg::NumChips];
	logic [11:0] n_env   [vcsc_pkg::NumChips];
	logic [11:0] n_ayt   [vcsc_pkg::NumChips][3];

	logic        emit, div_go;
	logic [7:0]  e_op, e_warn;
	logic [3:0]  e_cls;
	logic [31:0] e_off;
	logic [15:0] e_wait;

	logic        out_valid_q;
	logic [7:0]  op_q, warn_q;
	logic [3:0]  cls_q;
	logic [31:0] off_q;
	logic [15:0] wait_q;

	logic        accept, cfg_wr;
	vcsc_pkg::rem_status_t rem_st;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == vcsc_pkg::AddrSpt) ? {16'd0, spt_q} : dlen_q;

	always_comb begin
		vcsc_pkg::cmd_info_t ci;
		vcsc_pkg::cmd_info_t fi;
		logic        fin;
		logic [7:0]  f_op, val, regb;
		logic [31:0] f_off;
		logic        chip;
		logic [6:0]  rg;
		logic [1:0]  ti;
		logic [7:0]  w;

		n_phase = phase_q; n_left = left_q; n_pos = pos_q; n_args = args_q;
		n_opoff = opoff_q; n_unsup = unsup_q; n_payload = payload_q;
		n_stopped = stopped_q; n_parity = parity_q; n_warned = warned_q;
		n_latch = latch_q; n_wcnt = wcnt_q;
		n_tone = tone_q; n_noise = noise_q; n_env = env_q; n_ayt = ayt_q;
		if (restart) begin
			n_phase = '0; n_left = '0; n_pos = '0; n_args = '0; n_opoff = '0;
			n_unsup = '0; n_payload = 1'b0; n_stopped = 1'b0; n_parity = 1'b0;
			n_warned = '0; n_latch = 3'd4; n_wcnt = '0;
			for (int c = 0; c < vcsc_pkg::NumChips; c++) begin
				n_tone[c] = '0; n_noise[c] = '0; n_env[c] = '0;
				for (int t = 0; t < 3; t++) n_ayt[c][t] = '0;
			end
		end
		emit = 1'b0; div_go = 1'b0;
		e_op = data_byte; e_cls = vcsc_pkg::ClsUnknown; e_off = n_pos;
		e_wait = '0; e_warn = '0;
		fin = 1'b0; f_op = data_byte; f_off = n_pos;
		ci = vcsc_pkg::cmd_info(data_byte);
		w = '0;
		chip = 1'b0; rg = '0; ti = '0;

		if (!n_stopped) begin
			if (n_phase == 8'd0) begin
				if (n_pos >= dlen_q) begin
					n_stopped = 1'b1;
				end else begin
					n_pos = n_pos + 32'd1;
					if (ci.len == 4'd0) begin
						n_stopped = 1'b1;
						emit = 1'b1;
					end else begin
						n_args = '0;
						if (ci.len == 4'd1) begin
							fin = 1'b1;
						end else begin
							n_phase = data_byte;
							n_left = 32'(ci.len) - 32'd1;
							n_opoff = f_off;
							n_payload = 1'b0;
						end
					end
				end
			end else begin
				n_pos = n_pos + 32'd1;
				n_left = n_left - 32'd1;
				f_op = n_phase;
				f_off = n_opoff;
				if (n_payload) begin
					if (n_left == '0) begin
						n_payload = 1'b0;
						fin = 1'b1;
					end
				end else begin
					n_args = {data_byte, n_args[31:8]};
					if (n_left == '0) begin
						if (n_phase == vcsc_pkg::OpBlock && n_args != '0) begin
							n_left = n_args;
							n_payload = 1'b1;
						end else begin
							fin = 1'b1;
						end
					end
				end
			end
		end

		fi = vcsc_pkg::cmd_info(f_op);
		val = n_args[31:24];
		regb = n_args[23:16];
		if (fin) begin
			emit = 1'b1;
			e_op = f_op; e_cls = fi.cls; e_off = f_off;
			if (fi.cls == vcsc_pkg::ClsPsg) begin
				chip = vcsc_pkg::pick_chip(f_op == vcsc_pkg::OpPsgHi);
				if (!val[7]) begin
					if (n_latch == 3'd2) begin
						n_tone[chip] = {val[5:0], n_tone[chip][3:0]};
						n_wcnt = n_wcnt + 2'd1;
					end else if (n_latch == 3'd3) begin
						n_noise[chip] = val[3:0];
					end
				end else if (!val[4]) begin
					n_latch = {1'b0, val[6:5]};
					if (val[6:5] == 2'd2) begin
						n_tone[chip] = {6'd0, val[3:0]};
						n_wcnt = n_wcnt + 2'd1;
					end else if (val[6:5] == 2'd3) begin
						n_noise[chip] = val[3:0];
					end
				end
				if (n_wcnt >= 2'd2) begin
					n_wcnt = '0;
					if (n_noise[chip][1:0] == 2'd3 && n_tone[chip] > 10'h1f)
						w = w | (vcsc_pkg::WarnNoiseRate & ~n_warned);
				end
				if ((val & 8'hf3) == 8'he2) w = w | (vcsc_pkg::WarnFixed & ~n_warned);
				if ((val & 8'hf4) == 8'he0) w = w | (vcsc_pkg::WarnPeriodic & ~n_warned);
			end else if (fi.cls == vcsc_pkg::ClsAy) begin
				chip = vcsc_pkg::pick_chip(regb[7]);
				rg = regb[6:0];
				if (rg == 7'd11) n_env[chip] = {n_env[chip][11:8], val};
				if (rg == 7'd12) n_env[chip] = {val[3:0], n_env[chip][7:0]};
				if (rg == 7'd13 && n_env[chip] < 12'd1000)
					w = w | (vcsc_pkg::WarnEnvelope & ~n_warned);
				if (rg < 7'd6) begin
					ti = rg[2:1];
					if (!rg[0]) n_ayt[chip][ti] = {n_ayt[chip][ti][11:8], val};
					else n_ayt[chip][ti] = {val[3:0], n_ayt[chip][ti][7:0]};
					n_parity = !n_parity;
					if (!n_parity && (n_ayt[chip][0] > 12'h3ff ||
							n_ayt[chip][1] > 12'h3ff || n_ayt[chip][2] > 12'h3ff))
						w = w | (vcsc_pkg::WarnTone & ~n_warned);
				end
			end else if (f_op == vcsc_pkg::OpWait) begin
				e_wait = n_args[31:16];
				if (spt_q != '0 && !n_warned[3]) begin
					div_go = 1'b1;
					emit = 1'b0;
				end
			end else if (fi.cls == vcsc_pkg::ClsFine) begin
				w = vcsc_pkg::WarnFine & ~n_warned;
			end else if (fi.cls == vcsc_pkg::ClsEnd) begin
				n_stopped = 1'b1;
			end
			n_warned = n_warned | w;
			if (fi.grp_v && !n_unsup[fi.grp]) begin
				n_unsup[fi.grp] = 1'b1;
				w = w | vcsc_pkg::WarnUnsup;
			end
			n_phase = '0;
			e_warn = w;
		end
	end

	vcsc_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept && div_go),
		.dividend (e_wait),
		.divisor  (spt_q),
		.status   (rem_st)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			spt_q <= 16'd735; dlen_q <= '1;
			phase_q <= '0; left_q <= '0; pos_q <= '0; args_q <= '0; opoff_q <= '0;
			unsup_q <= '0; payload_q <= 1'b0; stopped_q <= 1'b0; parity_q <= 1'b0;
			warned_q <= '0; latch_q <= 3'd4; wcnt_q <= '0;
			for (int c = 0; c < vcsc_pkg::NumChips; c++) begin
				tone_q[c] <= '0; noise_q[c] <= '0; env_q[c] <= '0;
				for (int t = 0; t < 3; t++) ayt_q[c][t] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (paddr[2])
					vcsc_pkg::AddrSpt:  spt_q  <= pwdata[15:0];
					vcsc_pkg::AddrDlen: dlen_q <= pwdata;
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q <= n_phase; left_q <= n_left; pos_q <= n_pos;
						args_q <= n_args; opoff_q <= n_opoff; unsup_q <= n_unsup;
						payload_q <= n_payload; stopped_q <= n_stopped;
						parity_q <= n_parity; warned_q <= n_warned;
						latch_q <= n_latch; wcnt_q <= n_wcnt;
						tone_q <= n_tone; noise_q <= n_noise;
						env_q <= n_env; ayt_q <= n_ayt;
						op_q <= e_op; cls_q <= e_cls; off_q <= e_off;
						wait_q <= e_wait; warn_q <= e_warn;
						out_valid_q <= emit;
						if (div_go) state_q <= ST_DIV;
					end else if (out_valid_q && !out_stall) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (rem_st.done) begin
						if (rem_st.nonzero) begin
							warned_q <= warned_q | vcsc_pkg::WarnOddWait;
							warn_q <= vcsc_pkg::WarnOddWait;
						end
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign opcode         = op_q;
	assign command_class  = cls_q;
	assign command_offset = off_q;
	assign wait_samples   = wait_q;
	assign warnings       = warn_q;

`include "vgm_command_stream_checker_top_macros.svh"

	`VCSC_ASSERT(a_div_blocks_input, (state_q == ST_DIV) |-> in_stall, "input taken during remainder")
	`VCSC_ASSERT(a_done_in_div, rem_st.done |-> (state_q == ST_DIV), "remainder done while idle")
	`VCSC_ASSERT_NEXT(a_div_emits, (state_q == ST_DIV) && rem_st.done, out_valid, "wait record lost")

endmodule

// ===== rtl/core/vcsc_rem.sv =====
// Bit-serial remainder unit for the wait divisibility check
module vcsc_rem (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [15:0]           dividend,
	input  logic [15:0]           divisor,
	output vcsc_pkg::rem_status_t status
);

	logic [16:0] rem_q;
	logic [15:0] dvd_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;

	assign trial = {rem_q[15:0], dvd_q[15]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			dvd_q  <= '0;
			dvs_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				dvd_q  <= dividend;
				dvs_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= (trial >= {1'b0, dvs_q}) ? trial - {1'b0, dvs_q} : trial;
				dvd_q <= {dvd_q[14:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd15) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign status.done    = done_q;
	assign status.nonzero = (rem_q != '0);

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the command stream checker: predicted records compared per field
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] RegSptAddr  = 3'd0;
	localparam logic [2:0] RegDlenAddr = 3'd4;
	localparam int         DrainCycles = 40;

	class stream_scoreboard;
		typedef struct {
			logic [7:0]  op;
			logic [3:0]  cls;
			logic [31:0] ofs;
			logic [15:0] wt;
			logic [7:0]  warn;
		} record_t;

		record_t     record_q[$];
		int unsigned errors;
		logic [15:0] spt;
		logic [31:0] dlen;

		logic [7:0]  cur_op;
		logic [31:0] left_cnt;
		logic [31:0] pos;
		logic [31:0] args;
		bit          in_pay;
		logic [31:0] op_ofs;
		bit          halted;
		logic [7:0]  warned;
		logic [31:0] unsup_seen;
		int          latch_ch;
		logic [9:0]  tone_per[2];
		logic [3:0]  noise_ctl[2];
		int          wr_cnt;
		logic [11:0] env_per[2];
		logic [11:0] ay_tone[2][3];
		bit          ay_par;

		function new();
			spt = 16'd735;
			dlen = '1;
			clear();
		endfunction

		function void clear();
			cur_op = 0; left_cnt = 0; pos = 0; args = 0; in_pay = 0; op_ofs = 0;
			halted = 0; warned = 0; unsup_seen = 0; latch_ch = 4; wr_cnt = 0; ay_par = 0;
			for (int c = 0; c < 2; c++) begin
				tone_per[c] = 0; noise_ctl[c] = 0; env_per[c] = 0;
				for (int k = 0; k < 3; k++) ay_tone[c][k] = 0;
			end
		endfunction

		function void set_reg(logic [2:0] addr, logic [31:0] v);
			if (addr == RegSptAddr) spt = v[15:0];
			else dlen = v;
		endfunction

		function void lookup(logic [7:0] op, output int len, output logic [3:0] cls,
				output int grp);
			grp = -1; cls = vcsc_pkg::ClsUnsup; len = 0;
			if (op == 8'h30 || op == 8'h50) begin
				cls = vcsc_pkg::ClsPsg; len = 2;
			end else if (op >= 8'h70 && op <= 8'h7f) begin
				cls = vcsc_pkg::ClsFine; len = 1;
			end else if (op >= 8'h80 && op <= 8'h8f) begin
				cls = vcsc_pkg::ClsQuiet; len = 1;
			end else if (op >= 8'hc0 && op <= 8'hc4) begin
				grp = 22 + op - 8'hc0; len = 4;
			end else if (op >= 8'hd0 && op <= 8'hd4) begin
				grp = 27 + op - 8'hd0; len = 4;
			end else begin
				case (op)
					8'h4f, 8'h94: begin cls = vcsc_pkg::ClsQuiet; len = 2; end
					8'h52, 8'h53, 8'ha2, 8'ha3, 8'hb3, 8'hb4, 8'hbb: begin
						cls = vcsc_pkg::ClsQuiet; len = 3;
					end
					8'h92: begin cls = vcsc_pkg::ClsQuiet; len = 6; end
					8'h93: begin cls = vcsc_pkg::ClsQuiet; len = 11; end
					8'he0, 8'hff: begin cls = vcsc_pkg::ClsQuiet; len = 5; end
					8'h61: begin cls = vcsc_pkg::ClsWait; len = 3; end
					8'h62, 8'h63: begin cls = vcsc_pkg::ClsWait; len = 1; end
					8'h66: begin cls = vcsc_pkg::ClsEnd; len = 1; end
					8'ha0: begin cls = vcsc_pkg::ClsAy; len = 3; end
					8'h67: begin cls = vcsc_pkg::ClsBlock; grp = 10; len = 7; end
					8'h68: begin cls = vcsc_pkg::ClsBlock; grp = 11; len = 12; end
					8'h90, 8'h91, 8'h95: begin grp = 12; len = 5; end
					8'h51: begin grp = 0; len = 3; end
					8'h54: begin grp = 1; len = 3; end
					8'h55: begin grp = 2; len = 3; end
					8'h56, 8'h57: begin grp = 3; len = 3; end
					8'h58, 8'h59: begin grp = 4; len = 3; end
					8'h5a: begin grp = 5; len = 3; end
					8'h5b: begin grp = 6; len = 3; end
					8'h5c: begin grp = 7; len = 3; end
					8'h5d: begin grp = 8; len = 3; end
					8'h5e, 8'h5f: begin grp = 9; len = 3; end
					8'hb0: begin grp = 13; len = 3; end
					8'hb1: begin grp = 14; len = 3; end
					8'hb2: begin grp = 15; len = 3; end
					8'hb5: begin grp = 16; len = 3; end
					8'hb6: begin grp = 17; len = 3; end
					8'hb7: begin grp = 18; len = 3; end
					8'hb8: begin grp = 19; len = 3; end
					8'hb9: begin grp = 20; len = 3; end
					8'hba: begin grp = 21; len = 3; end
					default: begin cls = vcsc_pkg::ClsUnknown; len = 0; end
				endcase
			end
		endfunction

		function logic [7:0] warn_once(logic [7:0] b);
			if ((warned & b) != 0) return 8'h00;
			warned |= b;
			return b;
		endfunction

		function logic [7:0] psg_update(int chip, logic [7:0] v);
			logic [7:0] w;
			w = 0;
			if (!v[7]) begin
				if (latch_ch == 2) begin
					tone_per[chip] = {v[5:0], tone_per[chip][3:0]};
					wr_cnt++;
				end else if (latch_ch == 3) begin
					noise_ctl[chip] = v[3:0];
				end
			end else if (!v[4]) begin
				latch_ch = v[6:5];
				if (latch_ch == 2) begin
					tone_per[chip] = {6'd0, v[3:0]};
					wr_cnt++;
				end else if (latch_ch == 3) begin
					noise_ctl[chip] = v[3:0];
				end
			end
			if (wr_cnt >= 2) begin
				wr_cnt = 0;
				if (noise_ctl[chip][1:0] == 2'b11 && tone_per[chip] > 10'h1f)
					w |= warn_once(vcsc_pkg::WarnNoiseRate);
			end
			if ((v & 8'hf3) == 8'he2) w |= warn_once(vcsc_pkg::WarnFixed);
			if ((v & 8'hf4) == 8'he0) w |= warn_once(vcsc_pkg::WarnPeriodic);
			return w;
		endfunction

		function logic [7:0] ay_update(logic [7:0] rb, logic [7:0] v);
			logic [7:0] w;
			int chip, rg;
			w = 0;
			chip = (rb[7] < vcsc_pkg::NumChips) ? rb[7] : vcsc_pkg::NumChips - 1;
			rg = rb[6:0];
			if (rg == 11) env_per[chip][7:0] = v;
			if (rg == 12) env_per[chip][11:8] = v[3:0];
			if (rg == 13 && env_per[chip] < 12'd1000) w |= warn_once(vcsc_pkg::WarnEnvelope);
			if (rg < 6) begin
				if (rg % 2 == 0) ay_tone[chip][rg / 2][7:0] = v;
				else ay_tone[chip][rg / 2][11:8] = v[3:0];
				ay_par = !ay_par;
				if (!ay_par && (ay_tone[chip][0] > 12'h3ff || ay_tone[chip][1] > 12'h3ff ||
						ay_tone[chip][2] > 12'h3ff))
					w |= warn_once(vcsc_pkg::WarnTone);
			end
			return w;
		endfunction

		function void finish_cmd(logic [7:0] op, logic [31:0] ofs);
			int len, grp, sel;
			logic [3:0] cls;
			logic [7:0] w;
			logic [15:0] wt;
			record_t rec;
			lookup(op, len, cls, grp);
			w = 0; wt = 0;
			if (cls == vcsc_pkg::ClsPsg) begin
				sel = (op == vcsc_pkg::OpPsgHi) ? 1 : 0;
				w = psg_update((sel < vcsc_pkg::NumChips) ? sel : vcsc_pkg::NumChips - 1,
					args[31:24]);
			end else if (cls == vcsc_pkg::ClsAy) begin
				w = ay_update(args[23:16], args[31:24]);
			end else if (op == vcsc_pkg::OpWait) begin
				wt = args[31:16];
				if (spt != 0 && (wt % spt) != 0) w = warn_once(vcsc_pkg::WarnOddWait);
			end else if (cls == vcsc_pkg::ClsFine) begin
				w = warn_once(vcsc_pkg::WarnFine);
			end else if (cls == vcsc_pkg::ClsEnd) begin
				halted = 1;
			end
			if (grp >= 0 && !unsup_seen[grp]) begin
				unsup_seen[grp] = 1'b1;
				w |= vcsc_pkg::WarnUnsup;
			end
			cur_op = 0;
			rec = '{op, cls, ofs, wt, w};
			record_q.push_back(rec);
		endfunction

		function void note_request(logic [7:0] b, logic rst);
			int len, grp;
			logic [3:0] cls;
			logic [31:0] at;
			record_t rec;
			if (rst) clear();
			if (halted) return;
			if (cur_op == 0) begin
				at = pos;
				if (pos >= dlen) begin
					halted = 1;
					return;
				end
				pos++;
				lookup(b, len, cls, grp);
				if (len == 0) begin
					halted = 1;
					rec = '{b, vcsc_pkg::ClsUnknown, at, 16'd0, 8'd0};
					record_q.push_back(rec);
					return;
				end
				args = 0;
				if (len == 1) begin
					finish_cmd(b, at);
					return;
				end
				cur_op = b; left_cnt = len - 1; op_ofs = at; in_pay = 0;
				return;
			end
			pos++;
			left_cnt--;
			if (in_pay) begin
				if (left_cnt != 0) return;
				in_pay = 0;
				finish_cmd(cur_op, op_ofs);
				return;
			end
			args = {b, args[31:8]};
			if (left_cnt != 0) return;
			if (cur_op == vcsc_pkg::OpBlock && args != 0) begin
				left_cnt = args;
				in_pay = 1;
				return;
			end
			finish_cmd(cur_op, op_ofs);
		endfunction

		function void check_record(logic [7:0] op, logic [3:0] cls, logic [31:0] ofs,
				logic [15:0] wt, logic [7:0] warn);
			record_t e;
			if (record_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected record op=%h cls=%0d ofs=%0d", op, cls, ofs);
				return;
			end
			e = record_q.pop_front();
			if (e.op !== op || e.cls !== cls || e.ofs !== ofs || e.wt !== wt ||
					e.warn !== warn) begin
				errors++;
				if (errors <= 10)
					$display("mismatch exp op=%h cls=%0d ofs=%0d wait=%0d warn=%h",
						e.op, e.cls, e.ofs, e.wt, e.warn,
						" / got op=%h cls=%0d ofs=%0d wait=%0d warn=%h",
						op, cls, ofs, wt, warn);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        restart;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  opcode;
	logic [3:0]  command_class;
	logic [31:0] command_offset;
	logic [15:0] wait_samples;
	logic [7:0]  warnings;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	stream_scoreboard sb;
	logic [8:0] request_q[$];
	bit calm;
	bit need_restart;
	int stall_hold;
	int stall_pick;

	vgm_command_stream_checker_top DUT (.*);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk) begin
		if (stall_hold == 0) begin
			stall_pick = $urandom_range(0, 99);
			out_stall <= (stall_pick >= 70) && !calm;
			stall_hold <= (stall_pick >= 97) ? $urandom_range(10, 40) : $urandom_range(0, 3);
		end else begin
			stall_hold <= stall_hold - 1;
		end
	end

	always @(posedge clk)
		if (arst_n && sb != null && out_valid && !out_stall)
			sb.check_record(opcode, command_class, command_offset, wait_samples, warnings);

	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task send_requests();
		logic [8:0] item;
		int g;
		while (request_q.size() != 0) begin
			item = request_q.pop_front();
			g = gap_len();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= item[7:0];
			restart <= item[8];
			@(posedge clk);
			while (in_stall) @(posedge clk);
			sb.note_request(item[7:0], item[8]);
		end
		in_valid <= 1'b0;
	endtask

	task drain();
		while (sb.record_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task write_reg(logic [2:0] addr, logic [31:0] v);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.set_reg(addr, v);
	endtask

	task push_bytes(logic [7:0] b[$]);
		foreach (b[i]) request_q.push_back({1'b0, b[i]});
	endtask

	function logic [7:0] pick_opcode();
		logic [7:0] others[] = '{8'h4f, 8'h94, 8'h52, 8'ha3, 8'hbb, 8'h92, 8'h93, 8'he0, 8'hff,
			8'h90, 8'h95, 8'h51, 8'h54, 8'h55, 8'h57, 8'h58, 8'h5a, 8'h5b, 8'h5c, 8'h5d,
			8'h5f, 8'hb0, 8'hb1, 8'hb2, 8'hb5, 8'hb6, 8'hb7, 8'hb8, 8'hb9, 8'hba, 8'hc0,
			8'hc4, 8'hd2, 8'hd4};
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return $urandom_range(0, 1) ? 8'h50 : 8'h30;
		if (r < 35) return 8'ha0;
		if (r < 47) return 8'h61;
		if (r < 51) return 8'h62 + 8'($urandom_range(0, 1));
		if (r < 55) return 8'h70 + 8'($urandom_range(0, 15));
		if (r < 59) return 8'h80 + 8'($urandom_range(0, 15));
		if (r < 64) return 8'h67;
		if (r < 66) return 8'h68;
		if (r < 94) return others[$urandom_range(0, others.size() - 1)];
		if (r < 96) return 8'h66;
		return 8'($urandom_range(0, 255));
	endfunction

	task gen_command();
		logic [7:0] op;
		logic [7:0] arg;
		logic [15:0] wt;
		int len, grp, sz, r;
		logic [3:0] cls;
		op = pick_opcode();
		sb.lookup(op, len, cls, grp);
		request_q.push_back({need_restart || ($urandom_range(0, 29) == 0), op});
		need_restart = (len == 0) || (cls == vcsc_pkg::ClsEnd);
		if (cls == vcsc_pkg::ClsPsg) begin
			r = $urandom_range(0, 3);
			arg = (r == 0) ? (8'hc0 | 8'($urandom_range(0, 15))) :
				(r == 1) ? (8'he0 | 8'($urandom_range(0, 15))) :
				(r == 2) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
			request_q.push_back({1'b0, arg});
		end else if (cls == vcsc_pkg::ClsAy) begin
			arg = $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255)) :
				8'($urandom_range(0, 13) | ($urandom_range(0, 1) << 7));
			request_q.push_back({1'b0, arg});
			request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
		end else if (op == vcsc_pkg::OpWait) begin
			wt = $urandom_range(0, 1) ? 16'(sb.spt * $urandom_range(0, 90)) :
				16'($urandom_range(0, 65535));
			request_q.push_back({1'b0, wt[7:0]});
			request_q.push_back({1'b0, wt[15:8]});
		end else if (op == vcsc_pkg::OpBlock) begin
			sz = $urandom_range(0, 5);
			request_q.push_back({1'b0, 8'h66});
			request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
			request_q.push_back({1'b0, 8'(sz)});
			repeat (3) request_q.push_back({1'b0, 8'h00});
			repeat (sz) request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
		end else if (len > 1) begin
			repeat (len - 1) request_q.push_back({1'b0, 8'($urandom_range(0, 255))});
		end
	endtask

	task run_phase(logic [15:0] spt, logic [31:0] dlen, int nbytes);
		write_reg(RegSptAddr, {16'd0, spt});
		write_reg(RegDlenAddr, dlen);
		calm = ($urandom_range(0, 3) == 0);
		need_restart = 1;
		while (request_q.size() < nbytes) gen_command();
		send_requests();
		drain();
	endtask

	initial begin
		sb = new();
		arst_n = 0; in_valid = 0; data_byte = 0; restart = 0; out_stall = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		stall_hold = 0; calm = 0; need_restart = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		request_q.push_back({1'b1, 8'h50});
		push_bytes('{8'he3, 8'h50, 8'hc5, 8'h50, 8'h3f, 8'h30, 8'he2, 8'ha0, 8'h0b, 8'h10,
			8'ha0, 8'h0d, 8'h00, 8'ha0, 8'h81, 8'h0f, 8'ha0, 8'h80, 8'hff, 8'h61, 8'h01,
			8'h00, 8'h61, 8'hff, 8'hff, 8'h62, 8'h7f, 8'h8f, 8'h67, 8'h66, 8'h00, 8'h02,
			8'h00, 8'h00, 8'h00, 8'haa, 8'h55, 8'h67, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00,
			8'h00, 8'hb0, 8'h12, 8'h34, 8'h00});
		request_q.push_back({1'b1, 8'h68});
		push_bytes('{8'h66, 8'h00, 8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff,
			8'hff, 8'h66, 8'h50});
		send_requests();
		drain();

		run_phase(16'd735, 32'hffff_ffff, 400);
		run_phase(16'd1, 32'hffff_ffff, 300);
		run_phase(16'd65535, 32'hffff_ffff, 300);
		run_phase(16'd0, 32'hffff_ffff, 300);
		run_phase(16'($urandom_range(1, 65535)), 32'd0, 100);
		run_phase(16'($urandom_range(1, 2000)), 32'($urandom_range(20, 300)), 300);
		run_phase(16'd735, 32'hffff_ffff, 300);

		if (sb.errors == 0 && sb.record_q.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
